/* src/bpi_pkg.sv */
package bpi_pkg;

	localparam int ACC_W     = 64;
	localparam int ACC_EXT_W = 72;
	localparam int OUT_W     = 48;
	localparam int NUM_TAPS  = 12;
	localparam int NUM_ACC   = 9;

	localparam logic [1:0] REG_MAP_ROWS  = 2'd0;
	localparam logic [1:0] REG_MAP_COLS  = 2'd1;
	localparam logic [1:0] REG_DERIVS_ON = 2'd2;

	localparam logic signed [ACC_EXT_W-1:0] ACC_LIM = ACC_EXT_W'(64'sh4000_0000_0000_0000);
	localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sh0000_8000_0000_0000;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [OUT_W-1:0] out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_FETCH,
		ST_TMAT,
		ST_AMAT,
		ST_EVAL,
		ST_HOLD
	} state_t;

	typedef enum logic [3:0] {
		ACC_SF,
		ACC_SFY,
		ACC_SFYY,
		ACC_F,
		ACC_DX,
		ACC_DXX,
		ACC_DY,
		ACC_DXY,
		ACC_DYY
	} acc_sel_t;

	typedef enum logic [1:0] {
		SRC_CF,
		SRC_SF,
		SRC_SFY,
		SRC_SFYY
	} src_sel_t;

	typedef struct packed {
		logic     en;
		acc_sel_t dst;
		src_sel_t src;
		logic [1:0] j;
		logic [2:0] k;
		logic     zero;
		logic     use_y;
	} op_t;

	// Clamp a widened sum back to the accumulator range of +-2^62.
	function automatic acc_t sat62(input logic signed [ACC_EXT_W-1:0] v);
		acc_t r;
		if (v > ACC_LIM) begin
			r = ACC_W'(ACC_LIM);
		end else if (v < -ACC_LIM) begin
			r = ACC_W'(-ACC_LIM);
		end else begin
			r = ACC_W'(v);
		end
		return r;
	endfunction

	// Halve with floor and saturate to the output width.
	function automatic out_t sat_out(input acc_t a);
		acc_t h;
		out_t r;
		h = a >>> 1;
		if (h > OUT_MAX) begin
			r = OUT_W'(OUT_MAX);
		end else if (h < OUT_MIN) begin
			r = OUT_W'(OUT_MIN);
		end else begin
			r = OUT_W'(h);
		end
		return r;
	endfunction

	// One row of the Horner program: slots 0..8 run along y, 9..14 along x.
	function automatic op_t op_of(input logic [3:0] slot, input logic [1:0] i);
		op_t o;
		o = '{en: 1'b1, dst: ACC_SF, src: SRC_CF, j: 2'd0, k: 3'd1, zero: 1'b0, use_y: 1'b1};
		case (slot)
			4'd0: begin o.dst = ACC_SF;   o.j = 2'd3; o.zero = 1'b1; end
			4'd1: begin o.dst = ACC_SFY;  o.j = 2'd3; o.k = 3'd3; o.zero = 1'b1; end
			4'd2: begin o.dst = ACC_SFYY; o.j = 2'd3; o.k = 3'd6; o.zero = 1'b1; end
			4'd3: begin o.dst = ACC_SF;   o.j = 2'd2; end
			4'd4: begin o.dst = ACC_SFY;  o.j = 2'd2; o.k = 3'd2; end
			4'd5: begin o.dst = ACC_SFYY; o.j = 2'd2; o.k = 3'd2; end
			4'd6: begin o.dst = ACC_SF;   o.j = 2'd1; end
			4'd7: begin o.dst = ACC_SFY;  o.j = 2'd1; end
			4'd8: begin o.dst = ACC_SF;   o.j = 2'd0; end
			4'd9: begin o.dst = ACC_F; o.src = SRC_SF; o.use_y = 1'b0; end
			4'd10: begin
				o.dst = ACC_DX; o.src = SRC_SF; o.use_y = 1'b0;
				o.k = {1'b0, i}; o.en = (i != 2'd0);
			end
			4'd11: begin
				o.dst = ACC_DXX; o.src = SRC_SF; o.use_y = 1'b0;
				o.k = (i == 2'd3) ? 3'd6 : 3'd2; o.en = i[1];
			end
			4'd12: begin o.dst = ACC_DY; o.src = SRC_SFY; o.use_y = 1'b0; end
			4'd13: begin
				o.dst = ACC_DXY; o.src = SRC_SFY; o.use_y = 1'b0;
				o.k = {1'b0, i}; o.en = (i != 2'd0);
			end
			4'd14: begin o.dst = ACC_DYY; o.src = SRC_SFYY; o.use_y = 1'b0; end
			default: o.en = 1'b0;
		endcase
		return o;
	endfunction

	// Neighborhood taps: row and column offsets 0..3 stand for -1..+2.
	function automatic logic [1:0] tap_row(input logic [3:0] n);
		logic [1:0] r;
		case (n)
			4'd0, 4'd1, 4'd8, 4'd10: r = 2'd1;
			4'd2, 4'd3, 4'd9, 4'd11: r = 2'd2;
			4'd4, 4'd5:              r = 2'd0;
			default:                 r = 2'd3;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] tap_col(input logic [3:0] n);
		logic [1:0] c;
		case (n)
			4'd0, 4'd2, 4'd4, 4'd6: c = 2'd1;
			4'd1, 4'd3, 4'd5, 4'd7: c = 2'd2;
			4'd8, 4'd9:             c = 2'd0;
			default:                c = 2'd3;
		endcase
		return c;
	endfunction

endpackage

/* src/bpi_map.sv */
module bpi_map #(
	parameter int DEPTH = 65536,
	parameter int AW = 16,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* src/bpi_wrap.sv */
module bpi_wrap #(
	parameter int MAX_N = 256,
	parameter int XW = 16,
	localparam int PW = $clog2(MAX_N + 1),
	localparam int IW = $clog2(MAX_N)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [XW-1:0] base,
	input  logic [PW-1:0]        period,
	output logic                 done,
	output logic [IW-1:0]        idx [4]
);
	localparam int CNW = $clog2(XW);

	logic           busy_q;
	logic [CNW-1:0] cnt_q;
	logic [XW-2:0]  bits_q;
	logic [PW-1:0]  r_q;
	logic [PW:0]    dbl, red, per_ext, r_inc, n1, n1_inc, n2;
	logic [PW-1:0]  p1;

	// Remainder one bit per cycle from the top; the sign bit weighs -1.
	assign per_ext = {1'b0, period};
	assign dbl = {r_q, bits_q[XW-2]};
	assign red = (dbl >= per_ext) ? dbl - per_ext : dbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNW'(XW - 1);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bits_q <= base[XW-2:0];
			r_q    <= base[XW-1] ? period - PW'(1) : '0;
		end else if (busy_q && cnt_q != '0) begin
			bits_q <= {bits_q[XW-3:0], 1'b0};
			r_q    <= PW'(red);
		end
	end

	assign done = busy_q && (cnt_q == '0);

	assign p1     = (r_q == '0) ? period - PW'(1) : r_q - PW'(1);
	assign r_inc  = {1'b0, r_q} + (PW + 1)'(1);
	assign n1     = (r_inc >= per_ext) ? r_inc - per_ext : r_inc;
	assign n1_inc = n1 + (PW + 1)'(1);
	assign n2     = (n1_inc >= per_ext) ? n1_inc - per_ext : n1_inc;

	assign idx[0] = IW'(p1);
	assign idx[1] = IW'(r_q);
	assign idx[2] = IW'(n1);
	assign idx[3] = IW'(n2);
endmodule

/* src/bpi_mac.sv */
module bpi_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  bpi_pkg::acc_t        cf [4][4],
	input  logic [FRAC_BITS-1:0] fx,
	input  logic [FRAC_BITS-1:0] fy,
	output logic                 done,
	output bpi_pkg::acc_t        acc [bpi_pkg::NUM_ACC]
);
	import bpi_pkg::*;

	localparam int PW = ACC_W + FRAC_BITS + 1;

	logic                 run_q;
	logic [5:0]           cnt_q;
	logic [1:0]           row_i;
	op_t                  op;
	acc_t                 acc_in;
	logic [FRAC_BITS-1:0] frac;
	logic signed [PW-1:0] prod;
	acc_t                 acc_q [NUM_ACC];
	logic                 v_s1, last_s1;
	op_t                  op_s1;
	acc_t                 mf_s1, cfv_s1, src_b, scaled;
	logic signed [ACC_EXT_W-1:0] sum;

	// Stage one: fractional multiply of the destination accumulator.
	assign row_i  = ~cnt_q[5:4];
	assign op     = op_of(cnt_q[3:0], row_i);
	assign acc_in = op.zero ? '0 : acc_q[op.dst];
	assign frac   = op.use_y ? fy : fx;
	assign prod   = PW'(acc_in) * $signed({1'b0, frac});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1    <= run_q && op.en;
			last_s1 <= run_q && (&cnt_q);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (&cnt_q) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= op;
		mf_s1  <= prod[FRAC_BITS+ACC_W-1:FRAC_BITS];
		cfv_s1 <= cf[row_i][op.j];
	end

	// Stage two: scale the addend by the derivative factor and accumulate.
	always_comb begin
		case (op_s1.src)
			SRC_CF:   src_b = cfv_s1;
			SRC_SF:   src_b = acc_q[ACC_SF];
			SRC_SFY:  src_b = acc_q[ACC_SFY];
			SRC_SFYY: src_b = acc_q[ACC_SFYY];
			default:  src_b = cfv_s1;
		endcase
	end

	assign scaled = sat62(ACC_EXT_W'(src_b) * $signed({1'b0, op_s1.k}));
	assign sum    = ACC_EXT_W'(mf_s1) + ACC_EXT_W'(scaled);

	always_ff @(posedge clk) begin
		if (start) begin
			for (int n = 0; n < NUM_ACC; n++) begin
				acc_q[n] <= '0;
			end
		end else if (v_s1) begin
			acc_q[op_s1.dst] <= sat62(sum);
		end
	end

	assign done = last_s1;
	assign acc  = acc_q;
endmodule

/* src/periodic_bicubic_map_interpolator.sv */
// Periodic bicubic map interpolator. The block keeps a MAX_ROWS x MAX_COLS map of
// signed samples and answers point queries with the bicubic spline value and its
// first and second derivatives, each as a 48-bit signed Q.FRAC_BITS number that
// saturates. A word with tuser low writes one sample and is absorbed in its own
// accept cycle; writes outside the store are dropped. A word with tuser high is a
// query at (x_coord, y_coord) in Q(32-FRAC_BITS).FRAC_BITS grid units; the map
// wraps with periods map_rows and map_cols (zero acts as one, anything above the
// maximum acts as the maximum). A query holds the block from its accept cycle to
// the next cycle that can accept a word, through these steps: the bit-serial
// remainder that wraps the cell index, twelve neighbor reads through the single
// read port of the sample memory, whose read data is registered, the coefficient
// matrix in two passes, the 16-coefficient Horner program over 64 program slots
// and a drain of the multiply-accumulate pipeline, which runs one multiply-accumulate
// per cycle through one shared fractional multiplier, and the load of the output
// register. That load waits for as long as an earlier result
// is still unclaimed. The block takes no word while a query is in work. A finished
// result sits in an output register, so the next word is accepted while it waits
// to be taken. Samples never written read as garbage; every query must only touch
// written entries (neighbors are fetched even with derivs_on clear, but then do
// not affect the result). Configuration may change only while the block is idle.
module periodic_bicubic_map_interpolator #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// row_index[7:0], col_index[15:8], sample_value[39:16], x_coord[71:40],
	// y_coord[103:72]
	input  logic [103:0] s_tdata,
	// func: 0 writes a sample, 1 runs a query
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// value[47:0], d_dx[95:48], d_dy[143:96], d2_dxx[191:144], d2_dyy[239:192],
	// d2_dxy[287:240]
	output logic [287:0] m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [8:0]   cfg_data
);
	import bpi_pkg::*;

	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int CLW   = $clog2(MAX_COLS + 1);
	localparam int RIW   = $clog2(MAX_ROWS);
	localparam int CIW   = $clog2(MAX_COLS);
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = 32 - FRAC_BITS;
	// Coefficient width: doubled samples grow by at most 9x in each matrix pass.
	localparam int CW    = SAMPLE_BITS + 10;

	// Configuration registers.
	logic [8:0] map_rows_q, map_cols_q;
	logic       derivs_on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_rows_q  <= 9'd256;
			map_cols_q  <= 9'd256;
			derivs_on_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_ROWS:  map_rows_q  <= cfg_data;
				REG_MAP_COLS:  map_cols_q  <= cfg_data;
				REG_DERIVS_ON: derivs_on_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Periods in use, clamped to one and to the store size.
	logic [31:0]    rows_ext, cols_ext;
	logic [RW-1:0]  rows_eff;
	logic [CLW-1:0] cols_eff;

	assign rows_ext = {23'd0, map_rows_q};
	assign cols_ext = {23'd0, map_cols_q};
	assign rows_eff = (rows_ext == 32'd0) ? RW'(1) :
		(rows_ext > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_ext);
	assign cols_eff = (cols_ext == 32'd0) ? CLW'(1) :
		(cols_ext > 32'(MAX_COLS)) ? CLW'(MAX_COLS) : CLW'(cols_ext);

	// Input word fields.
	logic [7:0]  row_in, col_in;
	logic [23:0] sample_in;
	logic [31:0] x_in, y_in;
	logic        accept, query_acc, write_acc;

	assign row_in    = s_tdata[7:0];
	assign col_in    = s_tdata[15:8];
	assign sample_in = s_tdata[39:16];
	assign x_in      = s_tdata[71:40];
	assign y_in      = s_tdata[103:72];
	assign accept    = s_tvalid && s_tready;
	assign query_acc = accept && s_tuser;
	assign write_acc = accept && !s_tuser;

	state_t state_q, state_d;
	logic   wrap_start, wrap_done, col_done, mac_start, mac_done, out_load;
	logic   fetch_issue, fetch_cap_q, fetch_last;
	logic [3:0] fc_q, tap_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (query_acc) state_d = ST_WRAP;
			ST_WRAP:  if (wrap_done) state_d = ST_FETCH;
			ST_FETCH: if (fetch_last) state_d = ST_TMAT;
			ST_TMAT:  state_d = ST_AMAT;
			ST_AMAT:  state_d = ST_EVAL;
			ST_EVAL:  if (mac_done) state_d = ST_HOLD;
			ST_HOLD:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = (state_q == ST_IDLE);
		wrap_start  = query_acc;
		fetch_issue = (state_q == ST_FETCH) && (fc_q < 4'(NUM_TAPS));
		mac_start   = (state_q == ST_AMAT);
		out_load    = (state_q == ST_HOLD) && (!m_tvalid || m_tready);
	end

	// Query fraction, kept for the whole evaluation.
	logic [FRAC_BITS-1:0] fx_q, fy_q;

	always_ff @(posedge clk) begin
		if (query_acc) begin
			fx_q <= x_in[FRAC_BITS-1:0];
			fy_q <= y_in[FRAC_BITS-1:0];
		end
	end

	// Cell index remainders, x against the row period and y against the column period.
	logic [RIW-1:0] row_list [4];
	logic [CIW-1:0] col_list [4];

	bpi_wrap #(.MAX_N(MAX_ROWS), .XW(XW)) u_wrap_row (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wrap_start),
		.base   ($signed(x_in[31:FRAC_BITS])),
		.period (rows_eff),
		.done   (wrap_done),
		.idx    (row_list)
	);

	bpi_wrap #(.MAX_N(MAX_COLS), .XW(XW)) u_wrap_col (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wrap_start),
		.base   ($signed(y_in[31:FRAC_BITS])),
		.period (cols_eff),
		.done   (col_done),
		.idx    (col_list)
	);

	// Sample store. Writes happen in the accept cycle; reads only while fetching.
	logic [31:0]            wr_addr32, rd_addr32;
	logic                   wr_en;
	logic [SAMPLE_BITS-1:0] rd_data;

	assign wr_addr32 = 32'(row_in) * 32'(MAX_COLS) + 32'(col_in);
	assign wr_en     = write_acc && (32'(row_in) < 32'(MAX_ROWS)) &&
		(32'(col_in) < 32'(MAX_COLS));
	assign rd_addr32 = 32'(row_list[tap_row(fc_q)]) * 32'(MAX_COLS) +
		32'(col_list[tap_col(fc_q)]);

	bpi_map #(.DEPTH(DEPTH), .AW(AW), .DW(SAMPLE_BITS)) u_map (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(wr_addr32)),
		.wdata (SAMPLE_BITS'($signed(sample_in))),
		.re    (fetch_issue),
		.raddr (AW'(rd_addr32)),
		.rdata (rd_data)
	);

	// Fetch sequencer: one read per cycle, data lands in the cycle after its read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q        <= '0;
			tap_d_q     <= '0;
			fetch_cap_q <= 1'b0;
		end else begin
			fetch_cap_q <= fetch_issue;
			tap_d_q     <= fc_q;
			if (wrap_start) begin
				fc_q <= '0;
			end else if (fetch_issue) begin
				fc_q <= fc_q + 1'b1;
			end
		end
	end

	assign fetch_last = fetch_cap_q && (tap_d_q == 4'(NUM_TAPS - 1));

	logic signed [SAMPLE_BITS-1:0] tap_q [NUM_TAPS];

	always_ff @(posedge clk) begin
		if (fetch_cap_q) begin
			tap_q[tap_d_q] <= $signed(rd_data);
		end
	end

	// Apply one row of the bicubic basis matrix to a vector.
	function automatic logic signed [CW-1:0] mrow(input logic [1:0] i,
		input logic signed [CW-1:0] v0, input logic signed [CW-1:0] v1,
		input logic signed [CW-1:0] v2, input logic signed [CW-1:0] v3);
		logic signed [CW-1:0] r;
		unique case (i)
			2'd0: r = v0;
			2'd1: r = v2;
			2'd2: r = (v1 <<< 1) + v1 - (v0 <<< 1) - v0 - (v2 <<< 1) - v3;
			2'd3: r = (v0 <<< 1) - (v1 <<< 1) + v2 + v3;
			default: r = v0;
		endcase
		return r;
	endfunction

	// Corner data at twice the sample scale. Taps 0..3 are the cell corners,
	// 4..7 the row neighbors and 8..11 the column neighbors.
	logic signed [CW-1:0] tx [NUM_TAPS];
	logic signed [CW-1:0] g [4][4];
	logic signed [CW-1:0] t_d [4][4];
	logic signed [CW-1:0] t_q [4][4];
	logic signed [CW-1:0] a_d [4][4];
	acc_t                 cf_d [4][4];
	acc_t                 cf_q [4][4];

	always_comb begin
		for (int n = 0; n < NUM_TAPS; n++) begin
			tx[n] = CW'(tap_q[n]);
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				g[r][c] = '0;
			end
		end
		g[0][0] = tx[0] <<< 1;
		g[0][1] = tx[1] <<< 1;
		g[1][0] = tx[2] <<< 1;
		g[1][1] = tx[3] <<< 1;
		if (derivs_on_q) begin
			g[2][0] = tx[2] - tx[4];
			g[2][1] = tx[3] - tx[5];
			g[3][0] = tx[6] - tx[0];
			g[3][1] = tx[7] - tx[1];
			g[0][2] = tx[1] - tx[8];
			g[0][3] = tx[10] - tx[0];
			g[1][2] = tx[3] - tx[9];
			g[1][3] = tx[11] - tx[2];
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int l = 0; l < 4; l++) begin
				t_d[i][l] = mrow(2'(i), g[0][l], g[1][l], g[2][l], g[3][l]);
				a_d[i][l] = mrow(2'(l), t_q[i][0], t_q[i][1], t_q[i][2], t_q[i][3]);
				cf_d[i][l] = sat62(ACC_EXT_W'(a_d[i][l]) <<< FRAC_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TMAT) begin
			t_q <= t_d;
		end
		if (state_q == ST_AMAT) begin
			cf_q <= cf_d;
		end
	end

	// Shared multiply-accumulate running the Horner program.
	acc_t acc_v [NUM_ACC];

	bpi_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.cf     (cf_q),
		.fx     (fx_q),
		.fy     (fy_q),
		.done   (mac_done),
		.acc    (acc_v)
	);

	// Output register.
	logic         m_tvalid_q;
	logic [287:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {sat_out(acc_v[ACC_DXY]), sat_out(acc_v[ACC_DYY]),
				sat_out(acc_v[ACC_DXX]), sat_out(acc_v[ACC_DY]),
				sat_out(acc_v[ACC_DX]), sat_out(acc_v[ACC_F])};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	a_mac_done_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_EVAL)
		else $error("multiply-accumulate finished outside evaluation");

	a_wrap_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_done |-> (state_q == ST_WRAP) && col_done)
		else $error("index remainders finished out of step");

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> state_q == ST_WRAP && !s_tready)
		else $error("accepted query did not start the wrap");

	a_fetch_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_cap_q |-> (state_q == ST_FETCH) && (tap_d_q < 4'(NUM_TAPS)))
		else $error("tap capture out of range");
`endif
endmodule
